### rtl/detection_box_overlay_core_defines.svh
// assertion macros for the detection box overlay core
`ifndef DETECTION_BOX_OVERLAY_CORE_DEFINES_SVH
`define DETECTION_BOX_OVERLAY_CORE_DEFINES_SVH

// checked only out of reset
`define DBO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define DBO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/dbo_pkg.sv
// types and constants shared by the detection box overlay modules
package dbo_pkg;

  localparam int COORD_W  = 10;
  localparam int SCALED_W = 20;
  localparam int COLOR_W  = 16;
  localparam int SLOT_W   = 3;
  localparam int CMD_W    = 2;

  localparam logic [COLOR_W-1:0] BAR_COLOR = 16'h0000;

  // command codes carried in the input tuser
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_DISP_W  = 3'd0;
  localparam logic [2:0] REG_DISP_H  = 3'd1;
  localparam logic [2:0] REG_SRC_W   = 3'd2;
  localparam logic [2:0] REG_SRC_H   = 3'd3;
  localparam logic [2:0] REG_BAR_H   = 3'd4;
  localparam logic [2:0] REG_COLOR   = 3'd5;

  // reset values of the configuration registers
  localparam logic [COORD_W-1:0] RST_DISP_W = 10'd368;
  localparam logic [COORD_W-1:0] RST_DISP_H = 10'd448;
  localparam logic [COORD_W-1:0] RST_SRC_W  = 10'd320;
  localparam logic [COORD_W-1:0] RST_SRC_H  = 10'd240;
  localparam logic [COORD_W-1:0] RST_BAR_H  = 10'd24;
  localparam logic [COLOR_W-1:0] RST_COLOR  = 16'hE007;

  // number of quotient bits, one per divider step
  localparam int DIV_STEPS = SCALED_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_DIV,
    SC_DONE
  } scale_state_t;

  typedef enum logic [1:0] {
    TOK_CLEAR,
    TOK_LOAD,
    TOK_PIXEL
  } tok_kind_t;

  // one scaled box on its way to a cell
  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic                box_ok;
    logic [SCALED_W-1:0] left;
    logic [SCALED_W-1:0] top;
    logic [SCALED_W-1:0] right;
    logic [SCALED_W-1:0] bottom;
  } dbo_box_t;

  // token that moves along the cell chain
  typedef struct packed {
    logic                vld;
    tok_kind_t           kind;
    dbo_box_t            box;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COLOR_W-1:0]  color;
    logic                draw;
    logic                hit;
  } dbo_tok_t;

endpackage

### rtl/dbo_scale.sv
// box corner scaler: one multiply and a bit-serial divide per corner
module dbo_scale
  import dbo_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [COORD_W-1:0]  left,
  input  logic [COORD_W-1:0]  top,
  input  logic [COORD_W-1:0]  right,
  input  logic [COORD_W-1:0]  bottom,
  input  logic [COORD_W-1:0]  disp_w,
  input  logic [COORD_W-1:0]  disp_h,
  input  logic [COORD_W-1:0]  src_w,
  input  logic [COORD_W-1:0]  src_h,
  input  logic                take,
  output logic                busy,
  output logic                done,
  output dbo_box_t            box
);

  scale_state_t         state_r, state_nxt;
  logic [1:0]           k_r, k_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]    slot_r;
  logic [COORD_W-1:0]   coord_r [4];
  logic [SCALED_W-1:0]  q_r [4];
  logic [SCALED_W-1:0]  quo_r, quo_nxt;
  logic [COORD_W-1:0]   rem_r, rem_nxt;
  logic [COORD_W-1:0]   num;
  logic [COORD_W-1:0]   divisor;
  logic [COORD_W:0]     trial;
  logic                 q_we;

  // odd corners are vertical
  assign num     = k_r[0] ? disp_h : disp_w;
  assign divisor = k_r[0] ? src_h : src_w;
  assign trial   = {rem_r, quo_r[SCALED_W-1]};

  // sequencer: next state and divider step
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    q_we      = 1'b0;
    unique case (state_r)
      SC_IDLE: begin
        if (start) begin
          state_nxt = SC_MUL;
          k_nxt     = 2'd0;
        end
      end
      SC_MUL: begin
        quo_nxt   = coord_r[k_r] * num;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = SC_DIV;
      end
      SC_DIV: begin
        if (trial >= {1'b0, divisor}) begin
          rem_nxt = COORD_W'(trial - {1'b0, divisor});
          quo_nxt = {quo_r[SCALED_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[COORD_W-1:0];
          quo_nxt = {quo_r[SCALED_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          q_we = 1'b1;
          if (k_r == 2'd3) begin
            state_nxt = SC_DONE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = SC_MUL;
          end
        end
      end
      SC_DONE: begin
        if (take) begin
          state_nxt = SC_IDLE;
        end
      end
      default: state_nxt = SC_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      k_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (state_r == SC_IDLE && start) begin
      slot_r     <= slot;
      coord_r[0] <= left;
      coord_r[1] <= top;
      coord_r[2] <= right;
      coord_r[3] <= bottom;
    end
    if (q_we) begin
      q_r[k_r] <= quo_nxt;
    end
  end

  assign busy = (state_r != SC_IDLE);
  assign done = (state_r == SC_DONE);

  // scaled box, kept only with positive width and height
  always_comb begin
    box.slot   = slot_r;
    box.left   = q_r[0];
    box.top    = q_r[1];
    box.right  = q_r[2];
    box.bottom = q_r[3];
    box.box_ok = (q_r[2] > q_r[0]) && (q_r[3] > q_r[1]);
  end

endmodule

### rtl/dbo_cell.sv
// one chain cell: holds one box, tests passing pixels, hands the token on
module dbo_cell
  import dbo_pkg::*;
#(
  parameter int IDX              = 0,
  parameter int BORDER_THICKNESS = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     advance,
  input  dbo_tok_t tok_i,
  output dbo_tok_t tok_o
);

  localparam logic [SCALED_W:0] BT = (SCALED_W + 1)'(BORDER_THICKNESS);

  logic                valid_r;
  logic [SCALED_W-1:0] left_r, top_r, right_r, bottom_r;
  dbo_tok_t            tok_r, tok_nxt;
  logic [SCALED_W:0]   px, py, l, t, r, b;
  logic                in_x, in_y, edge_x, edge_y, hit;
  logic                mine;

  assign px = (SCALED_W + 1)'(tok_i.x);
  assign py = (SCALED_W + 1)'(tok_i.y);
  assign l  = {1'b0, left_r};
  assign t  = {1'b0, top_r};
  assign r  = {1'b0, right_r};
  assign b  = {1'b0, bottom_r};

  // border test against the stored box
  assign in_x   = (px >= l) && (px < r);
  assign in_y   = (py >= t) && (py < b);
  assign edge_x = (px < l + BT) || (px + BT >= r);
  assign edge_y = (py < t + BT) || (py + BT >= b);
  assign hit    = valid_r && in_x && in_y && (edge_x || edge_y);

  assign mine = (int'(tok_i.box.slot) == IDX);

  always_comb begin
    tok_nxt     = tok_i;
    tok_nxt.hit = tok_i.hit || (tok_i.vld && tok_i.kind == TOK_PIXEL && tok_i.draw && hit);
  end

  // token stage and box valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
      valid_r   <= 1'b0;
    end else if (advance) begin
      tok_r.vld <= tok_i.vld;
      if (tok_i.vld && tok_i.kind == TOK_CLEAR) begin
        valid_r <= 1'b0;
      end else if (tok_i.vld && tok_i.kind == TOK_LOAD && mine) begin
        valid_r <= tok_i.box.box_ok;
      end
    end
  end

  // token payload and box corners
  always_ff @(posedge clk) begin
    if (advance) begin
      tok_r.kind  <= tok_nxt.kind;
      tok_r.box   <= tok_nxt.box;
      tok_r.x     <= tok_nxt.x;
      tok_r.y     <= tok_nxt.y;
      tok_r.color <= tok_nxt.color;
      tok_r.draw  <= tok_nxt.draw;
      tok_r.hit   <= tok_nxt.hit;
      if (tok_i.vld && tok_i.kind == TOK_LOAD && mine) begin
        left_r   <= tok_i.box.left;
        top_r    <= tok_i.box.top;
        right_r  <= tok_i.box.right;
        bottom_r <= tok_i.box.bottom;
      end
    end
  end

  assign tok_o = tok_r;

endmodule

### rtl/detection_box_overlay_core.sv
// top level: config registers, box scaler, cell chain and output register
//
//   channel  direction  payload
//   in_*     slave      tuser cmd, tdata box load fields and pixel fields
//   out_*    master     tdata result pixel position and color
//   cfg_*    apb slave  six overlay registers at byte addresses 0 to 20
//
// a pixel beat passes the cell chain and the output register. pixels
// and clears enter one per cycle while in_tready is high. a box load
// holds in_tready low while one shared multiplier and 1-bit-per-cycle
// divider scale its four corners. a stalled out beat freezes the whole
// chain. rst_n clears all boxes and restores the register defaults.
module detection_box_overlay_core
  import dbo_pkg::*;
#(
  parameter int MAX_BOXES        = 8,
  parameter int BORDER_THICKNESS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // cmd
  // box_slot, box_left, box_top, box_right, box_bottom, pixel_x, pixel_y,
  // pixel_color, one pad bit
  input  logic [79:0] in_tdata,
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_x, out_y, out_color, four pad bits
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [COORD_W-1:0] disp_w_r, disp_h_r, src_w_r, src_h_r, bar_h_r;
  logic [COLOR_W-1:0] color_r;
  logic [2:0]         reg_idx;
  logic               cfg_we;

  logic [CMD_W-1:0]   in_cmd;
  logic [SLOT_W-1:0]  in_slot;
  logic [COORD_W-1:0] in_left, in_top, in_right, in_bottom, in_x, in_y;
  logic [COLOR_W-1:0] in_color;

  logic               advance, in_fire, slot_ok, src_ok, in_disp;
  logic               sc_start, sc_busy, sc_done;
  dbo_box_t           sc_box;
  dbo_tok_t           head;
  dbo_tok_t           chain [MAX_BOXES+1];
  dbo_tok_t           last;

  logic               out_valid_r;
  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic [COLOR_W-1:0] out_color_r;

  // configuration registers
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_w_r <= RST_DISP_W;
      disp_h_r <= RST_DISP_H;
      src_w_r  <= RST_SRC_W;
      src_h_r  <= RST_SRC_H;
      bar_h_r  <= RST_BAR_H;
      color_r  <= RST_COLOR;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_DISP_W: disp_w_r <= cfg_pwdata[COORD_W-1:0];
        REG_DISP_H: disp_h_r <= cfg_pwdata[COORD_W-1:0];
        REG_SRC_W:  src_w_r  <= cfg_pwdata[COORD_W-1:0];
        REG_SRC_H:  src_h_r  <= cfg_pwdata[COORD_W-1:0];
        REG_BAR_H:  bar_h_r  <= cfg_pwdata[COORD_W-1:0];
        REG_COLOR:  color_r  <= cfg_pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      REG_DISP_W: cfg_prdata = 32'(disp_w_r);
      REG_DISP_H: cfg_prdata = 32'(disp_h_r);
      REG_SRC_W:  cfg_prdata = 32'(src_w_r);
      REG_SRC_H:  cfg_prdata = 32'(src_h_r);
      REG_BAR_H:  cfg_prdata = 32'(bar_h_r);
      REG_COLOR:  cfg_prdata = 32'(color_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // input field unpacking
  assign in_cmd    = in_tuser;
  assign in_slot   = in_tdata[2:0];
  assign in_left   = in_tdata[12:3];
  assign in_top    = in_tdata[22:13];
  assign in_right  = in_tdata[32:23];
  assign in_bottom = in_tdata[42:33];
  assign in_x      = in_tdata[52:43];
  assign in_y      = in_tdata[62:53];
  assign in_color  = in_tdata[78:63];

  // chain moves whenever the output register can take a beat
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance && !sc_busy;
  assign in_fire   = in_tvalid && in_tready;
  assign slot_ok   = (int'(in_slot) < MAX_BOXES);
  assign src_ok    = (src_w_r != '0) && (src_h_r != '0);
  assign in_disp   = (in_x < disp_w_r) && (in_y < disp_h_r);
  assign sc_start  = in_fire && (in_cmd == CMD_LOAD) && slot_ok && src_ok;

  dbo_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sc_start),
    .slot   (in_slot),
    .left   (in_left),
    .top    (in_top),
    .right  (in_right),
    .bottom (in_bottom),
    .disp_w (disp_w_r),
    .disp_h (disp_h_r),
    .src_w  (src_w_r),
    .src_h  (src_h_r),
    .take   (advance),
    .busy   (sc_busy),
    .done   (sc_done),
    .box    (sc_box)
  );

  // token entering the chain
  always_comb begin
    head = '0;
    if (sc_done) begin
      head.vld  = 1'b1;
      head.kind = TOK_LOAD;
      head.box  = sc_box;
    end else if (in_fire) begin
      unique case (in_cmd)
        CMD_CLEAR: begin
          head.vld  = 1'b1;
          head.kind = TOK_CLEAR;
        end
        CMD_LOAD: begin
          // zero source size empties the slot without scaling
          if (slot_ok && !src_ok) begin
            head.vld      = 1'b1;
            head.kind     = TOK_LOAD;
            head.box.slot = in_slot;
          end
        end
        CMD_PIXEL: begin
          head.vld   = 1'b1;
          head.kind  = TOK_PIXEL;
          head.x     = in_x;
          head.y     = in_y;
          head.color = (in_disp && in_y < bar_h_r) ? BAR_COLOR : in_color;
          head.draw  = in_disp && src_ok;
        end
        default: ;
      endcase
    end
  end

  assign chain[0] = head;

  // one cell per box slot
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    dbo_cell #(
      .IDX              (i),
      .BORDER_THICKNESS (BORDER_THICKNESS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .tok_i   (chain[i]),
      .tok_o   (chain[i+1])
    );
  end

  assign last = chain[MAX_BOXES];

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= last.vld && (last.kind == TOK_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_x_r     <= last.x;
      out_y_r     <= last.y;
      out_color_r <= last.hit ? color_r : last.color;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_color_r, out_y_r, out_x_r};

endmodule

### rtl/dbo_checker.sv
// port checker for the overlay core and its bind
`include "detection_box_overlay_core_defines.svh"

module dbo_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        cfg_pready
);

  // a held result keeps its beat
  `DBO_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "out beat changed while stalled")

  // a stalled output freezes the chain, so no input is taken
  `DBO_ASSERT(a_stall_blocks_in, out_tvalid && !out_tready |-> !in_tready, "input taken during output stall")

  // reset empties the output register
  `DBO_ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_tvalid, "out valid after reset")

  // config port never waits
  `DBO_ASSERT_ALWAYS(a_pready, cfg_pready, "cfg pready low")

endmodule

bind detection_box_overlay_core dbo_checker u_dbo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

### dv/tb_top.sv
// self-checking testbench for the detection box overlay core
`timescale 1ns / 1ps

module tb_top;
  import dbo_pkg::*;

  localparam int NUM_SLOTS = 8;
  localparam int EDGE_W = 2;
  localparam int PHASE_ITEMS = 236;
  localparam int HOLD_CYCLES = 400;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [15:0] color;
  } pixel_beat_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [79:0] data;
    bit          fixed;
    logic [15:0] fixed_color;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;
  logic [79:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // shadow of the overlay registers
  int unsigned disp_w = RST_DISP_W;
  int unsigned disp_h = RST_DISP_H;
  int unsigned src_w = RST_SRC_W;
  int unsigned src_h = RST_SRC_H;
  int unsigned bar_h = RST_BAR_H;
  logic [15:0] border_color = RST_COLOR;

  // shadow of the scaled box store
  bit          box_valid [NUM_SLOTS];
  int unsigned box_l [NUM_SLOTS];
  int unsigned box_t [NUM_SLOTS];
  int unsigned box_r [NUM_SLOTS];
  int unsigned box_b [NUM_SLOTS];

  pixel_beat_t pending_pixels [$];
  stim_row_t   directed_rows [$];
  int          fail_cnt = 0;
  int          src_idle_pct = 14;
  int          sink_idle_pct = 88;
  bit          hold_req = 1'b0;

  detection_box_overlay_core #(
    .MAX_BOXES       (NUM_SLOTS),
    .BORDER_THICKNESS(EDGE_W)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("Verification failed");
    $finish;
  end

  function automatic bit count_failure();
    fail_cnt++;
    return fail_cnt <= 10;
  endfunction

  // beat layout: slot, left, top, right, bottom, x, y, color, pad
  function automatic logic [79:0] pack_beat(int unsigned slot, int unsigned l, int unsigned t,
                                            int unsigned r, int unsigned b, int unsigned x,
                                            int unsigned y, int unsigned c);
    return {1'b0, c[15:0], y[9:0], x[9:0], b[9:0], r[9:0], t[9:0], l[9:0], slot[2:0]};
  endfunction

  function automatic stim_row_t mk_row(logic [1:0] cmd, int unsigned slot, int unsigned l,
                                       int unsigned t, int unsigned r, int unsigned b,
                                       int unsigned x, int unsigned y, int unsigned c,
                                       bit fixed, logic [15:0] fixed_color);
    stim_row_t row;
    row.cmd = cmd;
    row.data = pack_beat(slot, l, t, r, b, x, y, c);
    row.fixed = fixed;
    row.fixed_color = fixed_color;
    return row;
  endfunction

  function automatic void drop_box(int s);
    box_valid[s] = 1'b0;
    box_l[s] = 0;
    box_t[s] = 0;
    box_r[s] = 0;
    box_b[s] = 0;
  endfunction

  function automatic bit on_border(int s, int unsigned x, int unsigned y);
    if (!box_valid[s]) return 1'b0;
    if (x < box_l[s] || x >= box_r[s] || y < box_t[s] || y >= box_b[s]) return 1'b0;
    return (x < box_l[s] + EDGE_W) || (x + EDGE_W >= box_r[s]) ||
           (y < box_t[s] + EDGE_W) || (y + EDGE_W >= box_b[s]);
  endfunction

  // overlay predictor, applied to every accepted beat
  task automatic predict_overlay(input logic [1:0] cmd, input logic [79:0] d,
                                 output bit has_pixel, output pixel_beat_t px);
    int unsigned x1, y1, x2, y2, x, y;
    logic [15:0] col;
    bit in_disp;
    int s;
    has_pixel = 1'b0;
    px = '0;
    case (cmd)
      CMD_CLEAR: begin
        for (s = 0; s < NUM_SLOTS; s++) drop_box(s);
      end
      CMD_LOAD: begin
        s = int'(d[2:0]);
        if (src_w == 0 || src_h == 0) begin
          drop_box(s);
        end else begin
          x1 = 32'(d[12:3]) * disp_w / src_w;
          y1 = 32'(d[22:13]) * disp_h / src_h;
          x2 = 32'(d[32:23]) * disp_w / src_w;
          y2 = 32'(d[42:33]) * disp_h / src_h;
          if (x2 <= x1 || y2 <= y1) begin
            drop_box(s);
          end else begin
            box_valid[s] = 1'b1;
            box_l[s] = x1;
            box_t[s] = y1;
            box_r[s] = x2;
            box_b[s] = y2;
          end
        end
      end
      CMD_PIXEL: begin
        x = 32'(d[52:43]);
        y = 32'(d[62:53]);
        col = d[78:63];
        in_disp = (x < disp_w) && (y < disp_h);
        if (in_disp && y < bar_h) col = BAR_COLOR;
        // any border wins over the bar
        if (in_disp && src_w != 0 && src_h != 0) begin
          for (s = 0; s < NUM_SLOTS; s++) begin
            if (on_border(s, x, y)) col = border_color;
          end
        end
        has_pixel = 1'b1;
        px.x = d[52:43];
        px.y = d[62:53];
        px.color = col;
      end
      default: ;
    endcase
  endtask

  // one input beat, with an optional gap before it
  task automatic send_beat(input logic [1:0] cmd, input logic [79:0] d, input bit fixed,
                           input logic [15:0] fixed_color);
    bit has_pixel;
    pixel_beat_t px;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_overlay(cmd, d, has_pixel, px);
    if (has_pixel) begin
      if (fixed) px.color = fixed_color;
      pending_pixels.push_back(px);
    end
    @(negedge clk);
  endtask

  // apb write followed by a read back
  task automatic write_reg(input logic [2:0] idx, input int unsigned val);
    logic [31:0] rd;
    logic [31:0] masked;
    masked = (idx == REG_COLOR) ? (val & 32'hFFFF) : (val & 32'h3FF);
    cfg_paddr = {idx, 2'b00};
    cfg_pwrite = 1'b1;
    cfg_pwdata = val;
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_pwrite = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    case (idx)
      REG_DISP_W: disp_w = masked;
      REG_DISP_H: disp_h = masked;
      REG_SRC_W:  src_w = masked;
      REG_SRC_H:  src_h = masked;
      REG_BAR_H:  bar_h = masked;
      REG_COLOR:  border_color = masked[15:0];
      default: ;
    endcase
    if (rd !== masked && count_failure())
      $display("register %0d read back %h, expected %h", idx, rd, masked);
  endtask

  task automatic apply_settings(input int unsigned dw, input int unsigned dh,
                                input int unsigned sw, input int unsigned sh,
                                input int unsigned bar, input int unsigned col);
    write_reg(REG_DISP_W, dw);
    write_reg(REG_DISP_H, dh);
    write_reg(REG_SRC_W, sw);
    write_reg(REG_SRC_H, sh);
    write_reg(REG_BAR_H, bar);
    write_reg(REG_COLOR, col);
  endtask

  // coordinate on, next to or inside a box edge
  function automatic int unsigned near_edge(int unsigned lo, int unsigned hi);
    case ($urandom_range(7))
      0: return lo;
      1: return lo + 1;
      2: return lo + 2;
      3: return hi - 1;
      4: return hi - 2;
      5: return hi - 3;
      6: return $urandom_range(1) ? hi : lo - 1;
      default: return $urandom_range(hi - 1, lo);
    endcase
  endfunction

  // random beat: mostly pixels, some aimed at stored boxes, plus loads, clears and noise
  task automatic make_random_beat(output logic [1:0] cmd, output logic [79:0] d);
    int unsigned r, q, s, l, t, rt, b, x, y, sw_lim, sh_lim;
    r = $urandom_range(999);
    s = $urandom_range(NUM_SLOTS - 1);
    l = $urandom_range(1023);
    t = $urandom_range(1023);
    rt = $urandom_range(1023);
    b = $urandom_range(1023);
    x = $urandom_range(1023);
    y = $urandom_range(1023);
    if (r < 70) begin
      cmd = CMD_LOAD;
      sw_lim = (src_w == 0) ? 1023 : src_w;
      sh_lim = (src_h == 0) ? 1023 : src_h;
      if (r < 56) begin
        // box with its top left corner within the source size
        l = $urandom_range(sw_lim);
        t = $urandom_range(sh_lim);
        rt = l + $urandom_range(sw_lim / 3 + 1, 1);
        b = t + $urandom_range(sh_lim / 3 + 1, 1);
        if (rt > 1023) rt = 1023;
        if (b > 1023) b = 1023;
      end else if (r < 63) begin
        // empty or inverted box
        if ($urandom_range(1)) rt = $urandom_range(l);
        else b = $urandom_range(t);
      end
    end else if (r < 85) begin
      cmd = CMD_CLEAR;
    end else if (r < 95) begin
      cmd = CMD_UNUSED;
    end else begin
      cmd = CMD_PIXEL;
      q = $urandom_range(99);
      s = $urandom_range(NUM_SLOTS - 1);
      if (q < 45 && box_valid[s]) begin
        x = near_edge(box_l[s], box_r[s]);
        y = near_edge(box_t[s], box_b[s]);
      end else if (q < 70) begin
        x = $urandom_range(disp_w - 1);
        y = $urandom_range(disp_h - 1);
      end else if (q < 80) begin
        x = $urandom_range(disp_w - 1);
        y = (bar_h == 0) ? 0 : $urandom_range(bar_h - 1);
      end else if (q < 90) begin
        x = disp_w + $urandom_range(2) - 1;
        y = disp_h + $urandom_range(2) - 1;
      end
      s = $urandom_range(NUM_SLOTS - 1);
    end
    d = pack_beat(s, l, t, rt, b, x, y, $urandom_range(16'hFFFF));
  endtask

  // result check against the oldest predicted pixel
  task automatic check_pixel_beat(input logic [39:0] beat);
    pixel_beat_t got;
    pixel_beat_t want;
    got.x = beat[9:0];
    got.y = beat[19:10];
    got.color = beat[35:20];
    if (pending_pixels.size() == 0) begin
      if (count_failure())
        $display("unexpected pixel x=%0d y=%0d color=%h", got.x, got.y, got.color);
    end else begin
      want = pending_pixels.pop_front();
      if (got !== want && count_failure())
        $display("pixel mismatch: expected x=%0d y=%0d color=%h, got x=%0d y=%0d color=%h",
                 want.x, want.y, want.color, got.x, got.y, got.color);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_pixel_beat(out_tdata);
  end

  // result receiver with random stalls and one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // stimulus
  initial begin
    logic [1:0]  cmd;
    logic [79:0] beat;
    int          p;
    int          n_left;
    int          mode;
    in_tvalid = 1'b0;
    in_tuser = CMD_CLEAR;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    rst_n = 1'b0;
    for (p = 0; p < NUM_SLOTS; p++) drop_box(p);

    // directed table under the reset settings
    directed_rows.push_back(mk_row(CMD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 16'h1234, 1, 16'h0000));
    directed_rows.push_back(mk_row(CMD_PIXEL, 0, 0, 0, 0, 0, 0, 100, 16'hABCD, 1, 16'hABCD));
    directed_rows.push_back(mk_row(CMD_PIXEL, 0, 0, 0, 0, 0, 1023, 0, 16'hFFFF, 1, 16'hFFFF));
    directed_rows.push_back(mk_row(CMD_PIXEL, 0, 0, 0, 0, 0, 367, 23, 16'hFFFF, 1, 16'h0000));
    directed_rows.push_back(mk_row(CMD_PIXEL, 0, 0, 0, 0, 0, 367, 24, 16'h8001, 1, 16'h8001));
    directed_rows.push_back(mk_row(CMD_LOAD, 0, 10, 50, 100, 150, 0, 0, 0, 0, 16'h0));
    directed_rows.push_back(mk_row(CMD_PIXEL, 0, 0, 0, 0, 0, 11, 93, 16'h1111, 1, RST_COLOR));
    directed_rows.push_back(mk_row(CMD_PIXEL, 0, 0, 0, 0, 0, 50, 200, 16'h3333, 1, 16'h3333));
    directed_rows.push_back(mk_row(CMD_PIXEL, 0, 0, 0, 0, 0, 114, 150, 16'h4444, 1, RST_COLOR));
    directed_rows.push_back(mk_row(CMD_PIXEL, 0, 0, 0, 0, 0, 115, 150, 16'h5555, 1, 16'h5555));
    directed_rows.push_back(mk_row(CMD_LOAD, 7, 0, 0, 1023, 1023, 0, 0, 0, 0, 16'h0));
    directed_rows.push_back(mk_row(CMD_PIXEL, 0, 0, 0, 0, 0, 0, 30, 16'h0F0F, 0, 16'h0));
    directed_rows.push_back(mk_row(CMD_LOAD, 7, 5, 5, 5, 100, 0, 0, 0, 0, 16'h0));
    directed_rows.push_back(mk_row(CMD_PIXEL, 0, 0, 0, 0, 0, 0, 30, 16'h0F0F, 0, 16'h0));
    directed_rows.push_back(mk_row(CMD_LOAD, 3, 200, 10, 100, 20, 0, 0, 0, 0, 16'h0));
    directed_rows.push_back(mk_row(CMD_LOAD, 4, 0, 0, 40, 40, 0, 0, 0, 0, 16'h0));
    directed_rows.push_back(mk_row(CMD_PIXEL, 0, 0, 0, 0, 0, 20, 10, 16'h1234, 0, 16'h0));
    directed_rows.push_back(mk_row(CMD_PIXEL, 0, 0, 0, 0, 0, 20, 1, 16'h1234, 0, 16'h0));
    directed_rows.push_back(mk_row(CMD_UNUSED, 7, 1023, 1023, 1023, 1023, 1023, 1023,
                                   16'hFFFF, 0, 16'h0));
    directed_rows.push_back(mk_row(CMD_PIXEL, 7, 1023, 1023, 1023, 1023, 1023, 1023,
                                   16'hFFFF, 1, 16'hFFFF));
    directed_rows.push_back(mk_row(CMD_CLEAR, 7, 1023, 1023, 1023, 1023, 1023, 1023,
                                   16'hFFFF, 0, 16'h0));
    directed_rows.push_back(mk_row(CMD_PIXEL, 0, 0, 0, 0, 0, 11, 93, 16'h1111, 1, 16'h1111));
    directed_rows.push_back(mk_row(CMD_LOAD, 2, 300, 200, 320, 240, 0, 0, 0, 0, 16'h0));
    directed_rows.push_back(mk_row(CMD_PIXEL, 0, 0, 0, 0, 0, 367, 447, 16'hF0F0, 0, 16'h0));
    directed_rows.push_back(mk_row(CMD_PIXEL, 0, 0, 0, 0, 0, 0, 1023, 16'h5A5A, 1, 16'h5A5A));

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].cmd, directed_rows[i].data, directed_rows[i].fixed,
                directed_rows[i].fixed_color);

    // random phases, each under its own settings
    for (p = 0; p < 7; p++) begin
      if (p > 0) begin
        // drain, and let a trailing box load finish its scaling
        in_tvalid = 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (200) @(negedge clk);
        case (p)
          1: apply_settings(1023, 1023, 1, 1, 0, 16'hFFFF);
          2: apply_settings($urandom_range(1023, 1), $urandom_range(1023, 1), 0,
                            $urandom_range(1023, 1), $urandom_range(64), $urandom_range(16'hFFFF));
          4: apply_settings($urandom_range(1023, 1), $urandom_range(1023, 1),
                            $urandom_range(1023, 1), 0, $urandom_range(64),
                            $urandom_range(16'hFFFF));
          6: apply_settings(1, 1, 1023, 1023, 1023, 16'h0000);
          default: apply_settings($urandom_range(1023, 1), $urandom_range(1023, 1),
                                  $urandom_range(1023, 1), $urandom_range(1023, 1),
                                  $urandom_range(96), $urandom_range(16'hFFFF));
        endcase
      end
      // idling: sender light then heavy, receiver heavy then light, then none
      mode = (p * 3) / 7;
      src_idle_pct = (mode == 0) ? 14 : (mode == 1) ? 88 : 0;
      sink_idle_pct = (mode == 0) ? 88 : (mode == 1) ? 14 : 0;
      if (p == 5) hold_req = 1'b1;
      n_left = PHASE_ITEMS;
      while (n_left > 0) begin
        make_random_beat(cmd, beat);
        send_beat(cmd, beat, 1'b0, 16'h0);
        if (cmd != CMD_UNUSED) n_left--;
      end
    end

    in_tvalid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
